// File: design/integer_matrix_multiply_accumulate_unit_defines.svh
// Assertion macros shared by the RTL files.
`ifndef INTEGER_MATRIX_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_ACCUMULATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define IMMA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true out of reset
`define IMMA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IMMA_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMMA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: design/imma_pkg.sv
package imma_pkg;

    localparam int MAX_DIM_DEF = 32;
    localparam int VAL_W       = 32;
    localparam int REG_W       = 6;
    localparam int IDX_W       = 5;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [REG_W-1:0] REG_RESET = REG_W'(32);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A  = 3'd0,
        KIND_LOAD_B  = 3'd1,
        KIND_LOAD_C  = 3'd2,
        KIND_COMPUTE = 3'd3,
        KIND_READ_C  = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_INNER = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRD,
        ST_MAC,
        ST_DRN0,
        ST_DRN1,
        ST_WB
    } t_state;

    // sequencer controls seen by the MAC unit and the top level
    typedef struct packed {
        logic busy;
        logic c_rd;
        logic ab_rd;
        logic c_wr;
        logic done;
    } t_seq_ctl;

endpackage

// File: design/imma_ram.sv
module imma_ram #(
    parameter int DEPTH  = imma_pkg::MAX_DIM_DEF * imma_pkg::MAX_DIM_DEF,
    parameter int DATA_W = imma_pkg::VAL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/imma_mac.sv
module imma_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  imma_pkg::t_seq_ctl             i_ctl,
    input  logic [imma_pkg::VAL_W-1:0]     i_a,
    input  logic [imma_pkg::VAL_W-1:0]     i_b,
    input  logic [imma_pkg::VAL_W-1:0]     i_c,
    output logic [imma_pkg::VAL_W-1:0]     o_acc
);
    import imma_pkg::*;

    logic               r_c_ld;
    logic               r_ab_vld;
    logic               r_prod_vld;
    logic [VAL_W-1:0]   r_prod;
    logic [VAL_W-1:0]   r_acc;
    logic [2*VAL_W-1:0] full_prod;

    // memory read data is registered: align valids with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ld     <= 1'b0;
            r_ab_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_c_ld     <= i_ctl.c_rd;
            r_ab_vld   <= i_ctl.ab_rd;
            r_prod_vld <= r_ab_vld;
        end
    end

    assign full_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (r_ab_vld) begin
            r_prod <= full_prod[VAL_W-1:0];
        end
        if (r_c_ld) begin
            r_acc <= i_c;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: design/imma_seq.sv
`include "integer_matrix_multiply_accumulate_unit_defines.svh"

module imma_seq #(
    parameter  int MAX_DIM = imma_pkg::MAX_DIM_DEF,
    localparam int EW      = $clog2(MAX_DIM + 1),
    localparam int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [EW-1:0]      i_nr,
    input  logic [EW-1:0]      i_nc,
    input  logic [EW-1:0]      i_nk,
    output imma_pkg::t_seq_ctl o_ctl,
    output logic [AW-1:0]      o_a_addr,
    output logic [AW-1:0]      o_b_addr,
    output logic [AW-1:0]      o_c_addr
);
    import imma_pkg::*;

    localparam int DW = $clog2(MAX_DIM);

    t_state        r_state, n_state;
    logic [DW-1:0] r_i, n_i;
    logic [DW-1:0] r_j, n_j;
    logic [DW-1:0] r_k, n_k;
    logic          i_last, j_last, k_last;

    assign i_last = (EW'(r_i) + EW'(1)) == i_nr;
    assign j_last = (EW'(r_j) + EW'(1)) == i_nc;
    assign k_last = (EW'(r_k) + EW'(1)) == i_nk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_CRD;
            ST_CRD:  n_state = ST_MAC;
            ST_MAC:  if (k_last) n_state = ST_DRN0;
            ST_DRN0: n_state = ST_DRN1;
            ST_DRN1: n_state = ST_WB;
            ST_WB:   n_state = (j_last && i_last) ? ST_IDLE : ST_CRD;
            default: n_state = ST_IDLE;
        endcase
    end

    // loop counters: i over rows, j over cols, k over inner
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
            end
            ST_MAC: n_k = k_last ? '0 : r_k + DW'(1);
            ST_WB: begin
                if (j_last) begin
                    n_j = '0;
                    n_i = r_i + DW'(1);
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl       = '0;
        o_ctl.busy  = (r_state != ST_IDLE);
        o_ctl.c_rd  = (r_state == ST_CRD);
        o_ctl.ab_rd = (r_state == ST_MAC);
        o_ctl.c_wr  = (r_state == ST_WB);
        o_ctl.done  = (r_state == ST_WB) && j_last && i_last;
    end

    assign o_a_addr = AW'(r_i) * AW'(MAX_DIM) + AW'(r_k);
    assign o_b_addr = AW'(r_k) * AW'(MAX_DIM) + AW'(r_j);
    assign o_c_addr = AW'(r_i) * AW'(MAX_DIM) + AW'(r_j);

    `IMMA_ASSERT(a_wb_after_drain, i_clk, i_rst_n, r_state == ST_WB |-> $past(r_state) == ST_DRN1, "write-back without full drain")
    `IMMA_ASSERT(a_crd_entry, i_clk, i_rst_n, r_state == ST_CRD |-> $past(r_state) == ST_IDLE || $past(r_state) == ST_WB, "C read entered from wrong state")
    `IMMA_ASSERT(a_mac_exit, i_clk, i_rst_n, r_state == ST_MAC |=> r_state == ST_MAC || r_state == ST_DRN0, "MAC phase left without drain")

endmodule

// File: design/integer_matrix_multiply_accumulate_unit.sv
// Load A/B/C and read C: one transaction per cycle unless stalled. Compute: input is
// stalled while each of rows*cols elements gets a C read, inner MAC steps through the
// single shared multiplier, drain states DRN0/DRN1 and a C write-back. Each result
// passes s1 and the output register. Reset (synchronous, active low) clears handshake
// and sequencer state, sets the three size registers to 32, leaves A, B, C stores as is.
`include "integer_matrix_multiply_accumulate_unit_defines.svh"

module integer_matrix_multiply_accumulate_unit #(
    parameter int MAX_DIM = imma_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [imma_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [imma_pkg::REG_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [imma_pkg::KIND_W-1:0]         i_kind,
    input  logic [imma_pkg::IDX_W-1:0]          i_row,
    input  logic [imma_pkg::IDX_W-1:0]          i_col,
    input  logic signed [imma_pkg::VAL_W-1:0]   i_value,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [imma_pkg::VAL_W-1:0]   o_data,
    output logic                                o_status
);
    import imma_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(MAX_DIM + 1);        // width of an effective size
    localparam int CW    = (EW > REG_W) ? EW : REG_W;  // clamp compare width
    localparam int IW    = (EW > IDX_W) ? EW : IDX_W;  // index compare width

    // ------------------------------------------------------------------
    // Size registers. Raw value is kept; 0 acts as 1, above MAX_DIM as MAX_DIM.
    // ------------------------------------------------------------------
    logic [REG_W-1:0] r_rows, r_cols, r_inner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= REG_RESET;
            r_cols  <= REG_RESET;
            r_inner <= REG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:  r_rows  <= i_cfg_data;
                CFG_COLS:  r_cols  <= i_cfg_data;
                CFG_INNER: r_inner <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [EW-1:0] f_eff(input logic [REG_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (v == '0) begin
            f_eff = EW'(1);
        end else if (w > CW'(MAX_DIM)) begin
            f_eff = EW'(MAX_DIM);
        end else begin
            f_eff = EW'(w);
        end
    endfunction

    logic [EW-1:0] nr, nc, nk;

    assign nr = f_eff(r_rows);
    assign nc = f_eff(r_cols);
    assign nk = f_eff(r_inner);

    // ------------------------------------------------------------------
    // Handshake. Stage s1 holds an accepted transaction while the C store
    // read (if any) completes; the output register parts it from the sink.
    // ------------------------------------------------------------------
    t_seq_ctl   seq_ctl;
    logic       in_acc;
    logic       s1_mv;
    logic       r_s1_vld;
    logic       r_s1_rd;
    logic       r_s1_st;
    logic       r_out_vld;
    logic [VAL_W-1:0] r_out_data;
    logic       r_out_st;

    assign s1_mv   = r_s1_vld && (!r_out_vld || !i_stall);
    assign o_stall = seq_ctl.busy || (r_s1_vld && !s1_mv);
    assign in_acc  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Decode of the incoming transaction
    // ------------------------------------------------------------------
    logic row_lt_r, row_lt_k, col_lt_c, col_lt_k;
    logic hit_a, hit_b, hit_c, hit_rd, is_cmp, dec_st;

    assign row_lt_r = IW'(i_row) < IW'(nr);
    assign row_lt_k = IW'(i_row) < IW'(nk);
    assign col_lt_c = IW'(i_col) < IW'(nc);
    assign col_lt_k = IW'(i_col) < IW'(nk);

    always_comb begin
        hit_a  = 1'b0;
        hit_b  = 1'b0;
        hit_c  = 1'b0;
        hit_rd = 1'b0;
        is_cmp = 1'b0;
        dec_st = STATUS_OK;
        unique case (i_kind)
            KIND_LOAD_A: begin
                hit_a  = row_lt_r && col_lt_k;
                dec_st = hit_a ? STATUS_OK : STATUS_IGNORED;
            end
            KIND_LOAD_B: begin
                hit_b  = row_lt_k && col_lt_c;
                dec_st = hit_b ? STATUS_OK : STATUS_IGNORED;
            end
            KIND_LOAD_C: begin
                hit_c  = row_lt_r && col_lt_c;
                dec_st = hit_c ? STATUS_OK : STATUS_IGNORED;
            end
            KIND_COMPUTE: is_cmp = 1'b1;
            KIND_READ_C: begin
                hit_rd = row_lt_r && col_lt_c;
                dec_st = hit_rd ? STATUS_OK : STATUS_IGNORED;
            end
            default: dec_st = STATUS_IGNORED;
        endcase
    end

    // element (row, col) sits at row*MAX_DIM + col
    logic [AW-1:0] host_addr;

    assign host_addr = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);

    // ------------------------------------------------------------------
    // Sequencer, MAC unit and the three stores
    // ------------------------------------------------------------------
    logic [AW-1:0]    a_addr, b_addr, c_addr;
    logic [VAL_W-1:0] a_q, b_q, c_q, acc;
    logic             c_we, c_re;
    logic [AW-1:0]    c_waddr, c_raddr;
    logic [VAL_W-1:0] c_wdata;

    imma_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc && is_cmp),
        .i_nr     (nr),
        .i_nc     (nc),
        .i_nk     (nk),
        .o_ctl    (seq_ctl),
        .o_a_addr (a_addr),
        .o_b_addr (b_addr),
        .o_c_addr (c_addr)
    );

    imma_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (seq_ctl),
        .i_a     (a_q),
        .i_b     (b_q),
        .i_c     (c_q),
        .o_acc   (acc)
    );

    imma_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (VAL_W)
    ) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && hit_a),
        .i_waddr (host_addr),
        .i_wdata (i_value),
        .i_re    (seq_ctl.ab_rd),
        .i_raddr (a_addr),
        .o_rdata (a_q)
    );

    imma_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (VAL_W)
    ) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && hit_b),
        .i_waddr (host_addr),
        .i_wdata (i_value),
        .i_re    (seq_ctl.ab_rd),
        .i_raddr (b_addr),
        .o_rdata (b_q)
    );

    // C is shared: host loads/reads when idle, sequencer while busy
    assign c_we    = (in_acc && hit_c) || seq_ctl.c_wr;
    assign c_re    = (in_acc && hit_rd) || seq_ctl.c_rd;
    assign c_waddr = seq_ctl.busy ? c_addr : host_addr;
    assign c_raddr = seq_ctl.busy ? c_addr : host_addr;
    assign c_wdata = seq_ctl.busy ? acc : i_value;

    imma_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (VAL_W)
    ) u_c_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_q)
    );

    // ------------------------------------------------------------------
    // Result path
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // compute transaction reports only once write-back is done
            if (in_acc && !is_cmp) begin
                r_s1_vld <= 1'b1;
            end else if (seq_ctl.done) begin
                r_s1_vld <= 1'b1;
            end else if (s1_mv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_mv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && !is_cmp) begin
            r_s1_rd <= hit_rd;
            r_s1_st <= dec_st;
        end else if (seq_ctl.done) begin
            r_s1_rd <= 1'b0;
            r_s1_st <= STATUS_OK;
        end
        if (s1_mv) begin
            r_out_data <= r_s1_rd ? c_q : '0;
            r_out_st   <= r_s1_st;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_data   = r_out_data;
    assign o_status = r_out_st;

    `IMMA_ASSERT(a_cmp_goes_busy, i_clk, i_rst_n, in_acc && is_cmp |=> seq_ctl.busy, "compute accepted but sequencer idle")
    `IMMA_ASSERT_NEVER(a_c_port_clash, i_clk, i_rst_n, c_we && c_re, "C store written and read in one cycle")
    `IMMA_ASSERT(a_done_s1_free, i_clk, i_rst_n, seq_ctl.done |-> !r_s1_vld, "compute result would overwrite pending transaction")

endmodule
